@@ rtl/tfed_pkg.sv @@
// Package for the terminated frame event decoder: constants, state and handshake types.
package tfed_pkg;

    // Parameter defaults
    localparam int RX_CAP_DEF   = 64;
    localparam int TEXT_CAP_DEF = 32;

    // Protocol bytes
    localparam logic [7:0] TERM_BYTE   = 8'hFF;
    localparam logic [7:0] CODE_TOUCH  = 8'h65;
    localparam logic [7:0] CODE_NUMBER = 8'h71;
    localparam logic [7:0] CODE_STRING = 8'h70;

    // Event kinds
    localparam logic [1:0] KIND_TOUCH  = 2'd0;
    localparam logic [1:0] KIND_NUMBER = 2'd1;
    localparam logic [1:0] KIND_STRING = 2'd2;
    localparam logic [1:0] KIND_OTHER  = 2'd3;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_SEND
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic store;       // input word accepted
        logic load_event;  // load a single-word event into the output register
        logic start_str;   // begin streaming string characters
        logic load_char;   // load the character read from the buffer
        logic next_char;   // current character taken, advance
    } ctl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic term;        // incoming word closes a frame with a non-empty body
        logic str_chars;   // that frame is a string with at least one character
        logic more;        // further string characters remain after the current one
    } dp_stat_t;

endpackage

@@ rtl/terminated_frame_event_decoder_top.sv @@
// Top level of the terminated frame event decoder: stream ports, controller and datapath.
// Input: one byte word per cycle while no event is pending.
// Event: except for a string with characters, the result word is valid the cycle after the closing 0xFF is accepted.
// String: each character goes through buffer read, load and send in turn; the next read follows the taken send.
// Input is held off from a frame close until its last result word is taken.
// Reset (aresetn low, synchronous) clears the frame length and the state machine.
module terminated_frame_event_decoder_top #(
    parameter int RX_CAP   = tfed_pkg::RX_CAP_DEF,
    parameter int TEXT_CAP = tfed_pkg::TEXT_CAP_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] code, [15:8] page, [23:16] component, [31:24] touch_kind,
    // [63:32] number, [71:64] text_char
    output logic [71:0] m_tdata,
    output logic [2:0]  m_tuser,   // [1:0] event_kind, [2] text_valid
    output logic        m_tlast
);

    tfed_pkg::ctl_cmd_t cmd;
    tfed_pkg::dp_stat_t stat;

    logic [1:0]  event_kind;
    logic [7:0]  code, page, component, touch_kind, text_char;
    logic [31:0] number;
    logic        text_valid;

    tfed_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tfed_datapath #(
        .RX_CAP   (RX_CAP),
        .TEXT_CAP (TEXT_CAP)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rx_byte    (s_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .event_kind (event_kind),
        .code       (code),
        .page       (page),
        .component  (component),
        .touch_kind (touch_kind),
        .number     (number),
        .text_char  (text_char),
        .text_valid (text_valid),
        .last       (m_tlast)
    );

    // Pack the result word
    assign m_tdata = {text_char, number, touch_kind, component, page, code};
    assign m_tuser = {text_valid, event_kind};

endmodule

@@ rtl/tfed_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tfed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/tfed_ctrl.sv @@
// Controller state machine: input acceptance, string sequencing and output handshake.
module tfed_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  tfed_pkg::dp_stat_t stat,
    output tfed_pkg::ctl_cmd_t cmd
);

    tfed_pkg::state_t state_reg;
    tfed_pkg::state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tfed_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tfed_pkg::ST_IDLE: begin
                if (s_tvalid && stat.term) begin
                    state_next = stat.str_chars ? tfed_pkg::ST_READ : tfed_pkg::ST_SEND;
                end
            end
            tfed_pkg::ST_READ: begin
                state_next = tfed_pkg::ST_LOAD;
            end
            tfed_pkg::ST_LOAD: begin
                state_next = tfed_pkg::ST_SEND;
            end
            tfed_pkg::ST_SEND: begin
                if (m_tready) begin
                    state_next = stat.more ? tfed_pkg::ST_READ : tfed_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tfed_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath commands
    always_comb begin
        s_tready       = 1'b0;
        m_tvalid       = 1'b0;
        cmd            = '0;
        case (state_reg)
            tfed_pkg::ST_IDLE: begin
                s_tready       = 1'b1;
                cmd.store      = s_tvalid;
                cmd.load_event = s_tvalid && stat.term && !stat.str_chars;
                cmd.start_str  = s_tvalid && stat.term && stat.str_chars;
            end
            tfed_pkg::ST_READ: begin
                // buffer read in flight
            end
            tfed_pkg::ST_LOAD: begin
                cmd.load_char = 1'b1;
            end
            tfed_pkg::ST_SEND: begin
                m_tvalid      = 1'b1;
                cmd.next_char = m_tready && stat.more;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/tfed_datapath.sv @@
// Datapath: frame buffer, length and terminator tracking, header bytes, output register.
module tfed_datapath #(
    parameter int RX_CAP   = tfed_pkg::RX_CAP_DEF,
    parameter int TEXT_CAP = tfed_pkg::TEXT_CAP_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [7:0]         rx_byte,
    input  tfed_pkg::ctl_cmd_t cmd,
    output tfed_pkg::dp_stat_t stat,
    output logic [1:0]         event_kind,
    output logic [7:0]         code,
    output logic [7:0]         page,
    output logic [7:0]         component,
    output logic [7:0]         touch_kind,
    output logic [31:0]        number,
    output logic [7:0]         text_char,
    output logic               text_valid,
    output logic               last
);

    localparam int LW = $clog2(RX_CAP + 1);
    localparam int AW = $clog2(RX_CAP);
    localparam int TW = $clog2(TEXT_CAP);
    localparam int CW = (LW > TW) ? LW : TW;
    localparam logic [LW-1:0] CAP_L    = LW'(RX_CAP);
    localparam logic [CW-1:0] TEXT_MAX = CW'(TEXT_CAP - 1);

    // Frame tracking
    logic [LW-1:0] len_reg, len_next;
    logic [1:0]    run_reg, run_next;
    logic [7:0]    hdr_reg [5];

    // String sequencing
    logic [AW-1:0] idx_reg, idx_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic          str_reg, str_next;

    // Output word
    logic [1:0]  kind_reg;
    logic [7:0]  code_reg, page_reg, comp_reg, tk_reg, char_reg;
    logic [31:0] num_reg;
    logic        valid_reg, last_reg;

    logic          stored;
    logic          is_ff;
    logic [1:0]    run_inc;
    logic          term_raw;
    logic          body_ok;
    logic [CW-1:0] body_chars;
    logic [CW-1:0] n_chars;
    logic [7:0]    rd_data;

    // Terminator run and frame close detection on the incoming word
    always_comb begin
        stored     = (len_reg < CAP_L);
        is_ff      = (rx_byte == tfed_pkg::TERM_BYTE);
        run_inc    = (run_reg == 2'd3) ? 2'd3 : run_reg + 2'd1;
        term_raw   = stored && is_ff && (run_inc == 2'd3);
        body_ok    = (len_reg >= LW'(3));
        body_chars = CW'(len_reg) - CW'(3);
        n_chars    = (body_chars > TEXT_MAX) ? TEXT_MAX : body_chars;
        stat.term      = term_raw && body_ok;
        stat.str_chars = (hdr_reg[0] == tfed_pkg::CODE_STRING) && (len_reg > LW'(3));
        stat.more      = str_reg && (rem_reg > CW'(1));
    end

    // Length and run next values
    always_comb begin
        len_next = len_reg;
        run_next = run_reg;
        if (cmd.store) begin
            if (!stored || term_raw) begin
                len_next = '0;
                run_next = '0;
            end else begin
                len_next = len_reg + LW'(1);
                run_next = is_ff ? run_inc : 2'd0;
            end
        end
    end

    // String counters next values
    always_comb begin
        idx_next = idx_reg;
        rem_next = rem_reg;
        str_next = str_reg;
        if (cmd.start_str) begin
            idx_next = AW'(1);
            rem_next = n_chars;
            str_next = 1'b1;
        end else if (cmd.load_event) begin
            str_next = 1'b0;
        end else if (cmd.next_char) begin
            idx_next = idx_reg + AW'(1);
            rem_next = rem_reg - CW'(1);
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
            run_reg <= '0;
            str_reg <= 1'b0;
        end else begin
            len_reg <= len_next;
            run_reg <= run_next;
            str_reg <= str_next;
        end
    end

    // Sequencing payload registers
    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        rem_reg <= rem_next;
    end

    // Header bytes kept beside the buffer for touch and number decode
    always_ff @(posedge aclk) begin
        if (cmd.store && stored && (len_reg < LW'(5))) begin
            hdr_reg[len_reg[2:0]] <= rx_byte;
        end
    end

    // Frame buffer
    tfed_ram #(
        .WIDTH (8),
        .DEPTH (RX_CAP)
    ) u_buf (
        .aclk  (aclk),
        .we    (cmd.store && stored),
        .waddr (len_reg[AW-1:0]),
        .wdata (rx_byte),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.load_event) begin
            code_reg  <= hdr_reg[0];
            page_reg  <= '0;
            comp_reg  <= '0;
            tk_reg    <= '0;
            num_reg   <= '0;
            char_reg  <= '0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b1;
            if ((hdr_reg[0] == tfed_pkg::CODE_TOUCH) && (len_reg >= LW'(6))) begin
                kind_reg <= tfed_pkg::KIND_TOUCH;
                page_reg <= hdr_reg[1];
                comp_reg <= hdr_reg[2];
                tk_reg   <= hdr_reg[3];
            end else if ((hdr_reg[0] == tfed_pkg::CODE_NUMBER) && (len_reg >= LW'(7))) begin
                kind_reg <= tfed_pkg::KIND_NUMBER;
                num_reg  <= {hdr_reg[4], hdr_reg[3], hdr_reg[2], hdr_reg[1]};
            end else if (hdr_reg[0] == tfed_pkg::CODE_STRING) begin
                // empty string
                kind_reg <= tfed_pkg::KIND_STRING;
            end else begin
                kind_reg <= tfed_pkg::KIND_OTHER;
            end
        end else if (cmd.load_char) begin
            kind_reg  <= tfed_pkg::KIND_STRING;
            code_reg  <= tfed_pkg::CODE_STRING;
            page_reg  <= '0;
            comp_reg  <= '0;
            tk_reg    <= '0;
            num_reg   <= '0;
            char_reg  <= rd_data;
            valid_reg <= 1'b1;
            last_reg  <= (rem_reg == CW'(1));
        end
    end

    assign event_kind = kind_reg;
    assign code       = code_reg;
    assign page       = page_reg;
    assign component  = comp_reg;
    assign touch_kind = tk_reg;
    assign number     = num_reg;
    assign text_char  = char_reg;
    assign text_valid = valid_reg;
    assign last       = last_reg;

endmodule
